// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define CBF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never hold at a clock edge outside reset.
`define CBF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CBF_ASSERT(lbl, clk, rstn, prop, msg)
`define CBF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/cbf_pkg.sv -----
// Types, constants and the CRC-16 byte update for the command block framer.
// Depends on nothing; imported by every framer module.
`default_nettype none
package cbf_pkg;

    localparam int CBF_QUEUE_DEPTH = 4;
    localparam logic [15:0] CBF_CRC_POLY = 16'h8005;
    localparam logic [7:0] CBF_COUNT_EXTRA = 8'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] command_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Classified byte handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] count_byte;
        logic       first;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic crc_zero;
        logic mid_entry;
    } t_back_status;

    // One byte into the CRC, most significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = data[k] ^ c[15];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CBF_CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cbf_front.sv -----
// Front part of the framer: accepts command bytes, tracks the command length
// and marks first and last bytes. Depends on cbf_pkg.
`default_nettype none
module cbf_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire cbf_pkg::t_in_item      i_item,
    input  wire cbf_pkg::t_queue_status i_q_status,
    output logic                        o_full,
    output logic                        o_q_push,
    output cbf_pkg::t_entry             o_entry
);
    import cbf_pkg::*;

    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] len;
    logic       accept;

    assign o_full = i_q_status.full;
    assign accept = i_push && !i_q_status.full;
    assign o_q_push = accept;

    // A zero length is taken as a one-byte command.
    assign len = (i_item.command_length == 8'd0) ? 8'd1 : i_item.command_length;

    always_comb begin
        o_entry.data_byte  = i_item.data_byte;
        o_entry.count_byte = len + CBF_COUNT_EXTRA;
        if (r_remaining == 8'd0) begin
            o_entry.first = 1'b1;
            o_entry.last  = (len == 8'd1);
            n_remaining   = len - 8'd1;
        end else begin
            o_entry.first = 1'b0;
            o_entry.last  = (r_remaining == 8'd1);
            n_remaining   = r_remaining - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 8'd0;
        end else if (accept) begin
            r_remaining <= n_remaining;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbf_queue.sv -----
// Short register queue of classified bytes between the front and back parts.
// Depends on cbf_pkg.
`default_nettype none
module cbf_queue #(
    parameter int DEPTH = cbf_pkg::CBF_QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire cbf_pkg::t_entry        i_entry,
    input  wire logic                   i_pop,
    output cbf_pkg::t_entry             o_head,
    output cbf_pkg::t_queue_status      o_status
);
    import cbf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_cnt == FULL_CNT);
    assign o_status.empty = (r_cnt == '0);
    assign o_head = r_mem[r_rd];
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cbf_back.sv -----
// Back part of the framer: walks each command through count, data and
// CRC phases, keeps the running CRC and drives the output register.
// Depends on cbf_pkg.
`default_nettype none
module cbf_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cbf_pkg::t_entry        i_head,
    input  wire cbf_pkg::t_queue_status i_q_status,
    input  wire logic                   i_pop,
    output logic                        o_q_pop,
    output logic                        o_empty,
    output cbf_pkg::t_out_item          o_item,
    output cbf_pkg::t_back_status       o_status
);
    import cbf_pkg::*;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase_e;

    t_phase_e   r_phase;
    logic       r_in_entry;
    logic [15:0] r_crc;
    logic       r_out_valid;
    t_out_item  r_out;

    t_phase_e   phase;
    t_phase_e   n_phase;
    logic [15:0] n_crc;
    t_out_item  n_out;
    logic       done;
    logic       go;

    // The output register frees up when empty or when its word is taken.
    assign go = (!r_out_valid || i_pop) && !i_q_status.empty;
    assign phase = r_in_entry ? r_phase : (i_head.first ? PH_COUNT : PH_DATA);

    always_comb begin
        n_phase = phase;
        n_crc   = r_crc;
        n_out   = '0;
        done    = 1'b0;
        unique case (phase)
            PH_COUNT: begin
                n_out.out_byte = i_head.count_byte;
                n_crc          = crc_feed(r_crc, i_head.count_byte);
                n_phase        = PH_DATA;
            end
            PH_DATA: begin
                n_out.out_byte = i_head.data_byte;
                n_crc          = crc_feed(r_crc, i_head.data_byte);
                n_phase        = PH_CRC_HI;
                done           = !i_head.last;
            end
            PH_CRC_HI: begin
                n_out.out_byte = r_crc[15:8];
                n_phase        = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_out.out_byte = r_crc[7:0];
                n_out.out_last = 1'b1;
                n_crc          = 16'h0000;
                done           = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DATA;
            r_in_entry  <= 1'b0;
            r_crc       <= 16'h0000;
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out       <= n_out;
            r_out_valid <= 1'b1;
            r_crc       <= n_crc;
            r_phase     <= n_phase;
            r_in_entry  <= !done;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_q_pop = go && done;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;
    assign o_status.crc_zero  = (r_crc == 16'h0000);
    assign o_status.mid_entry = r_in_entry;

endmodule
`default_nettype wire

// ----- rtl/command_block_framer_crc16.sv -----
// Command block framer: count byte, command bytes, CRC-16 (poly 0x8005).
// An accepted byte is written into the queue and is then registered from the queue head into the output register.
// Throughput: one output word per cycle while each word is popped; a command of L bytes gives L + 3 output words
// through the single output register, and a queue of QUEUE_DEPTH entries absorbs the extras.
// Reset: synchronous, active low; empties the queue, clears the byte count and the CRC.
`default_nettype none
`include "assert_macros.svh"
module command_block_framer_crc16 #(
    parameter int QUEUE_DEPTH = cbf_pkg::CBF_QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire cbf_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output cbf_pkg::t_out_item      o_item
);
    import cbf_pkg::*;

    t_entry        front_entry;
    t_entry        q_head;
    t_queue_status q_status;
    t_back_status  back_status;
    logic          q_push;
    logic          q_pop;
    logic          last_shown;

    cbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_entry    (front_entry)
    );

    cbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    cbf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .i_pop      (pop),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .o_item     (o_item),
        .o_status   (back_status)
    );

    assign last_shown = !empty && o_item.out_last;

    // While the back part is part-way through an entry, that entry stays at the queue head.
    `CBF_ASSERT_NEVER(a_q_both, i_clk, i_rst_n, q_status.full && q_status.empty, "queue state")
    `CBF_ASSERT(a_crc_clear, i_clk, i_rst_n, last_shown |-> back_status.crc_zero, "CRC left set")
    `CBF_ASSERT(a_pop_needs_head, i_clk, i_rst_n, q_pop |-> !q_status.empty, "empty pop")
    `CBF_ASSERT(a_held, i_clk, i_rst_n, back_status.mid_entry |-> !q_status.empty, "entry lost")

endmodule
`default_nettype wire
